FILE: rtl/dual_motor_speed_ramp_controller_assert.svh
// Assertion macros shared by the motor ramp controller modules.
// Needs nothing else; modules include it by bare file name.
`ifndef DUAL_MOTOR_SPEED_RAMP_CONTROLLER_ASSERT_SVH
`define DUAL_MOTOR_SPEED_RAMP_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DMSR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define DMSR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/dmsr_pkg.sv
// Shared types and constants for the dual motor speed ramp controller.
// No dependencies.
`timescale 1ns / 1ps

package dmsr_pkg;

    localparam int DMSR_SPEED_LIMIT   = 1023;
    localparam int DMSR_SPEED_RESET   = 700;
    localparam int DMSR_INTERVAL_RST  = 5;
    localparam int DMSR_QUEUE_DEPTH   = 2;

    localparam int SPEED_VAL_W = 16;
    localparam int INTERVAL_W  = 16;
    localparam int DUTY_W      = 10;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 1;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_DIR   = 2'd1,
        REQ_RAMP  = 2'd2,
        REQ_SPEED = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        RAMP_KEEP = 2'd0,
        RAMP_UP   = 2'd1,
        RAMP_DOWN = 2'd2
    } ramp_t;

    // Decoded command handed from the front end to the execution side.
    typedef struct packed {
        req_t                   kind;
        logic                   apply_left;
        logic                   apply_right;
        dir_t                   left_dir;
        dir_t                   right_dir;
        ramp_t                  ramp;
        logic                   speed_ok;
        logic [SPEED_VAL_W-1:0] speed;
    } cmd_t;

endpackage

FILE: rtl/dmsr_front.sv
// Front end: unpacks input words, normalizes codes, range-checks the speed.
// Depends on dmsr_pkg.
`timescale 1ns / 1ps

module dmsr_front #(
    parameter int SPEED_LIMIT = dmsr_pkg::DMSR_SPEED_LIMIT
) (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dmsr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [dmsr_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           push,
    output dmsr_pkg::cmd_t                 push_cmd,
    input  logic                           queue_full
);
    import dmsr_pkg::*;

    function automatic dir_t norm_dir(input logic [1:0] code);
        dir_t d;
        case (code)
            DIR_FWD:  d = DIR_FWD;
            DIR_BACK: d = DIR_BACK;
            default:  d = DIR_STOP;
        endcase
        return d;
    endfunction

    function automatic ramp_t norm_ramp(input logic [1:0] code);
        ramp_t r;
        case (code)
            RAMP_UP:   r = RAMP_UP;
            RAMP_DOWN: r = RAMP_DOWN;
            default:   r = RAMP_KEEP;
        endcase
        return r;
    endfunction

    logic [SPEED_VAL_W-1:0] speed_value;

    assign speed_value = s_tdata[23:8];
    assign s_tready    = !queue_full;
    assign push        = s_tvalid && !queue_full;

    always_comb begin
        push_cmd.kind        = req_t'(s_tuser);
        push_cmd.apply_left  = s_tdata[0];
        push_cmd.apply_right = s_tdata[1];
        push_cmd.left_dir    = norm_dir(s_tdata[3:2]);
        push_cmd.right_dir   = norm_dir(s_tdata[5:4]);
        push_cmd.ramp        = norm_ramp(s_tdata[7:6]);
        push_cmd.speed_ok    = (speed_value < SPEED_VAL_W'(SPEED_LIMIT));
        push_cmd.speed       = speed_value;
    end

endmodule

FILE: rtl/dmsr_queue.sv
// Short command queue between front end and execution side.
// Depends on dmsr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dual_motor_speed_ramp_controller_assert.svh"

module dmsr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dmsr_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output dmsr_pkg::cmd_t head_cmd
);
    import dmsr_pkg::*;

    localparam int PTR_W = (DMSR_QUEUE_DEPTH > 1) ? $clog2(DMSR_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(DMSR_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DMSR_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DMSR_QUEUE_DEPTH);

    cmd_t             slot_reg [DMSR_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `DMSR_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= FULL_CNT)
    `DMSR_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, pop, count_reg != '0)
    `DMSR_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !pop,
                      count_reg == $past(count_reg) + 1'b1)

endmodule

FILE: rtl/dmsr_back.sv
// Execution side: per-side direction, ramp mode and speed, tick counter, ramp
// interval register and registered result word. Needs dmsr_pkg, assert macros.
`timescale 1ns / 1ps
`include "dual_motor_speed_ramp_controller_assert.svh"

module dmsr_back #(
    parameter int SPEED_LIMIT = dmsr_pkg::DMSR_SPEED_LIMIT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dmsr_pkg::INTERVAL_W-1:0] cfg_wdata,
    input  logic                            head_valid,
    input  dmsr_pkg::cmd_t                  head_cmd,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dmsr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [dmsr_pkg::M_TUSER_W-1:0]  m_tuser
);
    import dmsr_pkg::*;

    localparam int LIM_W = $clog2(SPEED_LIMIT);
    localparam int SPD_W = (LIM_W > DUTY_W) ? LIM_W : DUTY_W;
    localparam logic [SPD_W:0]   LIMIT_EXT = (SPD_W + 1)'(SPEED_LIMIT);
    localparam logic [SPD_W-1:0] SPD_RST   = SPD_W'(DMSR_SPEED_RESET);

    function automatic logic [SPD_W-1:0] ramp_step(input logic [SPD_W-1:0] spd,
                                                   input ramp_t mode);
        logic [SPD_W:0]   inc;
        logic [SPD_W-1:0] res;
        inc = {1'b0, spd} + 1'b1;
        res = spd;
        if (mode == RAMP_DOWN && spd != '0) begin
            res = spd - 1'b1;
        end else if (mode == RAMP_UP && inc < LIMIT_EXT) begin
            res = inc[SPD_W-1:0];
        end
        return res;
    endfunction

    logic [INTERVAL_W-1:0] interval_reg;
    dir_t                  ldir_reg, ldir_next, rdir_reg, rdir_next;
    ramp_t                 lramp_reg, lramp_next, rramp_reg, rramp_next;
    logic [SPD_W-1:0]      lspd_reg, lspd_next, rspd_reg, rspd_next;
    logic [INTERVAL_W-1:0] ticks_reg, ticks_next, ticks_inc;
    logic                  reject_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]  m_tuser_reg;
    logic [DUTY_W-1:0]     lduty, rduty;

    assign pop      = head_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Saturate the tick count at all ones.
    assign ticks_inc = (ticks_reg != '1) ? ticks_reg + 1'b1 : ticks_reg;

    always_comb begin
        ldir_next   = ldir_reg;
        rdir_next   = rdir_reg;
        lramp_next  = lramp_reg;
        rramp_next  = rramp_reg;
        lspd_next   = lspd_reg;
        rspd_next   = rspd_reg;
        ticks_next  = ticks_reg;
        reject_next = 1'b0;
        if (pop) begin
            case (head_cmd.kind)
                REQ_TICK: begin
                    ticks_next = ticks_inc;
                    if (ticks_inc > interval_reg) begin
                        lspd_next  = ramp_step(lspd_reg, lramp_reg);
                        rspd_next  = ramp_step(rspd_reg, rramp_reg);
                        ticks_next = '0;
                    end
                end
                REQ_DIR: begin
                    if (head_cmd.apply_left)  ldir_next = head_cmd.left_dir;
                    if (head_cmd.apply_right) rdir_next = head_cmd.right_dir;
                end
                REQ_RAMP: begin
                    if (head_cmd.apply_left)  lramp_next = head_cmd.ramp;
                    if (head_cmd.apply_right) rramp_next = head_cmd.ramp;
                end
                REQ_SPEED: begin
                    if (head_cmd.speed_ok) begin
                        if (head_cmd.apply_left)  lspd_next = SPD_W'(head_cmd.speed);
                        if (head_cmd.apply_right) rspd_next = SPD_W'(head_cmd.speed);
                    end else begin
                        reject_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        lduty = (ldir_next == DIR_STOP) ? '0 : lspd_next[DUTY_W-1:0];
        rduty = (rdir_next == DIR_STOP) ? '0 : rspd_next[DUTY_W-1:0];
        m_tdata_next = {rduty, lduty,
                        rdir_next == DIR_BACK, rdir_next == DIR_FWD,
                        ldir_next == DIR_BACK, ldir_next == DIR_FWD};
        if (pop) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_W'(DMSR_INTERVAL_RST);
            ldir_reg     <= DIR_STOP;
            rdir_reg     <= DIR_STOP;
            lramp_reg    <= RAMP_KEEP;
            rramp_reg    <= RAMP_KEEP;
            lspd_reg     <= SPD_RST;
            rspd_reg     <= SPD_RST;
            ticks_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                interval_reg <= cfg_wdata;
            end
            ldir_reg     <= ldir_next;
            rdir_reg     <= rdir_next;
            lramp_reg    <= lramp_next;
            rramp_reg    <= rramp_next;
            lspd_reg     <= lspd_next;
            rspd_reg     <= rspd_next;
            ticks_reg    <= ticks_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload loads only with a new word.
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= reject_next;
        end
    end

    `DMSR_ASSERT_NEXT(a_pop_loads, aclk, aresetn, pop, m_tvalid_reg)
    `DMSR_ASSERT_NOW(a_pins_exclusive, aclk, aresetn, m_tvalid_reg,
                     !(m_tdata_reg[0] && m_tdata_reg[1]) && !(m_tdata_reg[2] && m_tdata_reg[3]))
    `DMSR_ASSERT_NOW(a_stop_no_duty, aclk, aresetn,
                     m_tvalid_reg && !m_tdata_reg[0] && !m_tdata_reg[1],
                     m_tdata_reg[13:4] == '0)

endmodule

FILE: rtl/dual_motor_speed_ramp_controller.sv
// Top level of the dual motor speed ramp controller.
// Depends on dmsr_pkg, dmsr_front, dmsr_queue and dmsr_back.
`timescale 1ns / 1ps
//
// Usage:
// Input words arrive on s_ (tuser = request kind: tick, direction, ramp mode,
// set speed). Each word yields exactly one result word on m_: the four bridge
// pins, left and right duty in tdata, and the speed reject flag in tuser.
// cfg_we/cfg_wdata load the ramp interval in tick requests; write it only with
// no words in flight.
// Path: a word accepted on s_ is written into the queue, popped into the output
// register, presented on m_ and held until taken. Throughput is one word per
// cycle when m_tready does not stall it; the execution side commits a popped
// word and the output register refills on the same edge it is drained.
// A two-entry command queue sits between the front end and the execution
// side; when the receiver stalls, the output word holds, the queue fills and
// s_tready drops after two more words.
// Reset (aresetn low, synchronous) stops both sides, sets ramp mode to keep,
// both speeds to 700, the tick count to 0, the interval to 5, and empties
// the queue and output register.

module dual_motor_speed_ramp_controller #(
    parameter int SPEED_LIMIT = dmsr_pkg::DMSR_SPEED_LIMIT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // ramp_interval
    input  logic                            cfg_we,
    input  logic [dmsr_pkg::INTERVAL_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] apply_left, [1] apply_right, [3:2] left_dir_cmd, [5:4] right_dir_cmd,
    // [7:6] ramp_cmd, [23:8] speed_value
    input  logic [dmsr_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [dmsr_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] left_front_pin, [1] left_back_pin, [2] right_front_pin,
    // [3] right_back_pin, [13:4] left_duty, [23:14] right_duty
    output logic [dmsr_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] speed_rejected
    output logic [dmsr_pkg::M_TUSER_W-1:0]  m_tuser
);
    import dmsr_pkg::*;

    logic push, queue_full, pop, head_valid;
    cmd_t push_cmd, head_cmd;

    dmsr_front #(
        .SPEED_LIMIT(SPEED_LIMIT)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_cmd  (push_cmd),
        .queue_full(queue_full)
    );

    dmsr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_cmd  (head_cmd)
    );

    dmsr_back #(
        .SPEED_LIMIT(SPEED_LIMIT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head_valid(head_valid),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: sim/dual_motor_speed_ramp_controller_test.sv
// Self-checking bench for the dual motor speed ramp controller: directed and random stream
// traffic, idle bursts on both sides, each result word checked by an in-bench motor predictor.
// Depends on dmsr_pkg and dual_motor_speed_ramp_controller.
`timescale 1ns / 1ps

module dual_motor_speed_ramp_controller_test;
    import dmsr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        req_t        kind;
        logic        apply_left;
        logic        apply_right;
        logic [1:0]  left_code;
        logic [1:0]  right_code;
        logic [1:0]  ramp_code;
        logic [15:0] speed_value;
    } motor_cmd_t;

    typedef struct {
        logic              left_front;
        logic              left_back;
        logic              right_front;
        logic              right_back;
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              rejected;
    } bridge_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [INTERVAL_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [0] apply_left, [1] apply_right, [3:2] left_dir_cmd, [5:4] right_dir_cmd,
    // [7:6] ramp_cmd, [23:8] speed_value
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    // [1:0] req_type
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [0] left_front_pin, [1] left_back_pin, [2] right_front_pin,
    // [3] right_back_pin, [13:4] left_duty, [23:14] right_duty
    logic [M_TDATA_W-1:0]   m_tdata;
    // [0] speed_rejected
    logic [M_TUSER_W-1:0]   m_tuser;

    dual_motor_speed_ramp_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predictor state
    dir_t              left_dir_q   = DIR_STOP;
    dir_t              right_dir_q  = DIR_STOP;
    ramp_t             left_ramp_q  = RAMP_KEEP;
    ramp_t             right_ramp_q = RAMP_KEEP;
    logic [DUTY_W-1:0] left_speed_q  = DUTY_W'(DMSR_SPEED_RESET);
    logic [DUTY_W-1:0] right_speed_q = DUTY_W'(DMSR_SPEED_RESET);
    logic [15:0]       tick_count_q  = '0;
    logic [15:0]       interval_q    = 16'(DMSR_INTERVAL_RST);

    motor_cmd_t cmd_pending_q[$];
    bridge_t    bridge_expect_q[$];
    int         fail_count = 0;
    int         cycle_count = 0;
    bit         calm = 1'b0;

    function automatic dir_t decode_dir(logic [1:0] code);
        if (code == DIR_FWD) return DIR_FWD;
        if (code == DIR_BACK) return DIR_BACK;
        return DIR_STOP;
    endfunction

    function automatic ramp_t decode_ramp(logic [1:0] code);
        if (code == RAMP_UP) return RAMP_UP;
        if (code == RAMP_DOWN) return RAMP_DOWN;
        return RAMP_KEEP;
    endfunction

    function automatic logic [DUTY_W-1:0] ramp_next(logic [DUTY_W-1:0] spd, ramp_t mode);
        if (mode == RAMP_DOWN && spd > 0) return spd - 1'b1;
        if (mode == RAMP_UP && int'(spd) + 1 < DMSR_SPEED_LIMIT) return spd + 1'b1;
        return spd;
    endfunction

    // Apply one command to the predicted motor state and return the bridge word it yields.
    function automatic bridge_t advance_motors(motor_cmd_t c);
        bridge_t r;
        r.rejected = 1'b0;
        case (c.kind)
            REQ_TICK: begin
                if (tick_count_q != 16'hFFFF) tick_count_q = tick_count_q + 1'b1;
                if (tick_count_q > interval_q) begin
                    left_speed_q  = ramp_next(left_speed_q, left_ramp_q);
                    right_speed_q = ramp_next(right_speed_q, right_ramp_q);
                    tick_count_q  = '0;
                end
            end
            REQ_DIR: begin
                if (c.apply_left) left_dir_q = decode_dir(c.left_code);
                if (c.apply_right) right_dir_q = decode_dir(c.right_code);
            end
            REQ_RAMP: begin
                if (c.apply_left) left_ramp_q = decode_ramp(c.ramp_code);
                if (c.apply_right) right_ramp_q = decode_ramp(c.ramp_code);
            end
            default: begin
                if (int'(c.speed_value) < DMSR_SPEED_LIMIT) begin
                    if (c.apply_left) left_speed_q = c.speed_value[DUTY_W-1:0];
                    if (c.apply_right) right_speed_q = c.speed_value[DUTY_W-1:0];
                end else begin
                    r.rejected = 1'b1;
                end
            end
        endcase
        r.left_front  = (left_dir_q == DIR_FWD);
        r.left_back   = (left_dir_q == DIR_BACK);
        r.right_front = (right_dir_q == DIR_FWD);
        r.right_back  = (right_dir_q == DIR_BACK);
        r.left_duty   = (left_dir_q == DIR_STOP) ? '0 : left_speed_q;
        r.right_duty  = (right_dir_q == DIR_STOP) ? '0 : right_speed_q;
        return r;
    endfunction

    function automatic motor_cmd_t mk(req_t k, logic al, logic ar, logic [1:0] lc,
                                      logic [1:0] rc, logic [1:0] mc, logic [15:0] sv);
        motor_cmd_t c;
        c.kind = k;
        c.apply_left = al;
        c.apply_right = ar;
        c.left_code = lc;
        c.right_code = rc;
        c.ramp_code = mc;
        c.speed_value = sv;
        return c;
    endfunction

    function automatic motor_cmd_t random_cmd();
        motor_cmd_t c;
        int pick;
        int sel;
        pick = $urandom_range(0, 99);
        c = mk(REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
               2'($urandom_range(0, 3)), 16'($urandom_range(0, 1022)));
        if (pick >= 50) c.kind = REQ_DIR;
        if (pick >= 65) c.kind = REQ_RAMP;
        if (pick >= 80) c.kind = REQ_SPEED;
        sel = $urandom_range(0, 9);
        // bias speeds toward the ramp limits and the reject boundary
        if (sel == 0) c.speed_value = 16'($urandom_range(0, 65535));
        else if (sel == 1) c.speed_value = 16'($urandom_range(1019, 1026));
        else if (sel == 2) c.speed_value = 16'($urandom_range(0, 3));
        return c;
    endfunction

    // Driver: advance to the next pending word once the current one is taken.
    int         src_gap = 0;
    motor_cmd_t cur_cmd;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) bridge_expect_q.push_back(advance_motors(cur_cmd));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_pending_q.size() != 0) begin
                    cur_cmd = cmd_pending_q.pop_front();
                    s_tuser  <= cur_cmd.kind;
                    s_tdata  <= {cur_cmd.speed_value, cur_cmd.ramp_code, cur_cmd.right_code,
                                 cur_cmd.left_code, cur_cmd.apply_right, cur_cmd.apply_left};
                    s_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: receiver stalls in bursts, every taken word checked against the oldest prediction.
    int      snk_gap = 0;
    bridge_t got;
    bridge_t want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.left_front  = m_tdata[0];
                got.left_back   = m_tdata[1];
                got.right_front = m_tdata[2];
                got.right_back  = m_tdata[3];
                got.left_duty   = m_tdata[13:4];
                got.right_duty  = m_tdata[23:14];
                got.rejected    = m_tuser[0];
                if (bridge_expect_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected word: tdata=%h tuser=%h",
                                                   m_tdata, m_tuser);
                end else begin
                    want = bridge_expect_q.pop_front();
                    if (got.left_front !== want.left_front || got.left_back !== want.left_back
                        || got.right_front !== want.right_front
                        || got.right_back !== want.right_back
                        || got.left_duty !== want.left_duty
                        || got.right_duty !== want.right_duty
                        || got.rejected !== want.rejected) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp %b%b%b%b %0d/%0d %b, got %b%b%b%b %0d/%0d %b",
                                     want.right_back, want.right_front, want.left_back,
                                     want.left_front, want.left_duty, want.right_duty,
                                     want.rejected, got.right_back, got.right_front,
                                     got.left_back, got.left_front, got.left_duty,
                                     got.right_duty, got.rejected);
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) snk_gap = $urandom_range(1, 6);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** dual_motor_speed_ramp_controller: FAILED **");
            $finish;
        end
    end

    // Hold the sender until every predicted word has been taken.
    task automatic drain_all();
        while (cmd_pending_q.size() != 0 || s_tvalid || bridge_expect_q.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic load_interval(logic [15:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        interval_q = v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(logic [15:0] v, int n);
        load_interval(v);
        repeat (n) cmd_pending_q.push_back(random_cmd());
        drain_all();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: default interval of 5
        cmd_pending_q.push_back(mk(REQ_TICK, 1, 1, 3, 3, 3, 16'hFFFF));
        cmd_pending_q.push_back(mk(REQ_DIR, 1, 1, DIR_FWD, DIR_FWD, 0, 0));
        cmd_pending_q.push_back(mk(REQ_DIR, 1, 0, DIR_BACK, DIR_BACK, 0, 0));
        cmd_pending_q.push_back(mk(REQ_DIR, 0, 1, DIR_FWD, 2'd3, 0, 0));
        cmd_pending_q.push_back(mk(REQ_DIR, 0, 1, DIR_STOP, DIR_BACK, 0, 0));
        cmd_pending_q.push_back(mk(REQ_DIR, 0, 0, DIR_STOP, DIR_STOP, 0, 0));
        cmd_pending_q.push_back(mk(REQ_SPEED, 1, 1, 0, 0, 0, 16'd1022));
        cmd_pending_q.push_back(mk(REQ_SPEED, 1, 1, 0, 0, 0, 16'd1023));
        cmd_pending_q.push_back(mk(REQ_SPEED, 0, 0, 0, 0, 0, 16'hFFFF));
        cmd_pending_q.push_back(mk(REQ_SPEED, 0, 1, 0, 0, 0, 16'd0));
        cmd_pending_q.push_back(mk(REQ_SPEED, 1, 0, 0, 0, 0, 16'd0));
        cmd_pending_q.push_back(mk(REQ_SPEED, 0, 0, 0, 0, 0, 16'd500));
        cmd_pending_q.push_back(mk(REQ_SPEED, 1, 0, 0, 0, 0, 16'd1021));
        cmd_pending_q.push_back(mk(REQ_SPEED, 0, 1, 0, 0, 0, 16'd1));
        cmd_pending_q.push_back(mk(REQ_RAMP, 1, 0, 0, 0, RAMP_UP, 0));
        cmd_pending_q.push_back(mk(REQ_RAMP, 0, 1, 0, 0, RAMP_DOWN, 0));
        cmd_pending_q.push_back(mk(REQ_RAMP, 0, 0, 0, 0, 2'd3, 0));
        // tick five passes the interval and ramps both speeds to the limits; tick 11 holds them
        repeat (12) cmd_pending_q.push_back(mk(REQ_TICK, 0, 0, 0, 0, 0, 0));
        cmd_pending_q.push_back(mk(REQ_RAMP, 1, 1, 0, 0, 2'd3, 0));
        cmd_pending_q.push_back(mk(REQ_DIR, 1, 1, DIR_STOP, DIR_STOP, 0, 0));
        drain_all();

        random_phase(16'd0, 250);
        random_phase(16'hFFFF, 150);
        random_phase(16'd3, 250);
        random_phase(16'd1, 250);
        calm = 1'b1;
        random_phase(16'($urandom_range(0, 12)), 200);

        if (fail_count == 0 && bridge_expect_q.size() == 0) begin
            $display("** dual_motor_speed_ramp_controller: PASSED **");
        end else begin
            $display("** dual_motor_speed_ramp_controller: FAILED **");
        end
        $finish;
    end

endmodule
